/* hdl/pfa_pkg.sv */
// ============================================================================
// pfa_pkg: shared types and constants of the page frame allocator
// Frame table geometry, address windows, operation and status codes, and the
// command, result and frame-table port structs.
// ============================================================================
package pfa_pkg;

    localparam int NUM_FRAMES  = 65536;
    localparam int FRAME_IDX_W = $clog2(NUM_FRAMES);
    localparam int FRAME_CNT_W = FRAME_IDX_W + 1;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_NUM_W  = 32 - PAGE_SHIFT;
    localparam int COUNT_W     = 17;
    localparam int FLAG_W      = 2;

    // byte span of a region and page bound of a walk
    localparam int SPAN_W = 33;
    localparam int END_W  = PAGE_NUM_W + 2;

    localparam logic [FRAME_IDX_W-1:0] LAST_FRAME = FRAME_IDX_W'(NUM_FRAMES - 1);
    localparam logic [31:0] PAGE_MASK = 32'h0000_0FFF;

    // per-frame flags
    localparam int FLAG_AVAIL_BIT = 0;
    localparam int FLAG_USED_BIT  = 1;
    localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'b00;
    localparam logic [FLAG_W-1:0] FLAG_AVAIL = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_USED  = 2'b10;
    localparam logic [FLAG_W-1:0] FLAG_ALLOC = 2'b11;

    // frames whose base falls in these windows are never added
    localparam logic [31:0] MIN_REGION_BASE = 32'h0010_0000;
    localparam logic [31:0] LOW_WIN_LO      = 32'h0010_0000;
    localparam logic [31:0] LOW_WIN_HI      = 32'h0100_0000;
    localparam logic [31:0] HOLE_WIN_LO     = 32'h00F0_0000;
    localparam logic [31:0] HOLE_WIN_HI     = 32'h00FF_FFFF;
    localparam logic [31:0] HIGH_WIN_LO     = 32'hC000_0000;
    localparam logic [31:0] HIGH_WIN_HI     = 32'hFFFF_FFFF;

    // operation codes
    localparam logic [1:0] OP_REGION = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_MEMORY = 2'd1;
    localparam logic [1:0] STATUS_NO_RUN    = 2'd2;
    localparam logic [1:0] STATUS_NULL_FREE = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        address;
        logic [31:0]        length_bytes;
        logic               region_usable;
        logic [COUNT_W-1:0] frame_count;
    } pfa_cmd_t;

    typedef struct packed {
        logic [31:0]        base_address;
        logic [1:0]         status;
        logic [COUNT_W-1:0] total_frames;
        logic [COUNT_W-1:0] used_frames;
    } pfa_result_t;

    typedef struct packed {
        logic                   we;
        logic [FRAME_IDX_W-1:0] waddr;
        logic [FLAG_W-1:0]      wdata;
        logic [FRAME_IDX_W-1:0] raddr;
    } pfa_ram_req_t;

endpackage

/* hdl/pfa_flag_ram.sv */
// ============================================================================
// pfa_flag_ram: frame flag table
// One write port and one read port, read data registered.
// A read and a write of the same entry in one cycle return the old data.
// ============================================================================
module pfa_flag_ram
    import pfa_pkg::*;
(
    input  logic              clk,
    input  pfa_ram_req_t      req,
    output logic [FLAG_W-1:0] rdata
);

    logic [FLAG_W-1:0] flag_mem [NUM_FRAMES];
    logic [FLAG_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            flag_mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= flag_mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/pfa_engine.sv */
// ============================================================================
// pfa_engine: allocator sequencer
// Clears the flag table after reset, then runs each command that touches frames
// as a walk over the table: one read issued per cycle, read-modify-write in the cycle after.
// ============================================================================
module pfa_engine
    import pfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pfa_cmd_t          cmd,
    input  logic [31:0]       image_top,
    output logic              busy,
    output logic              done,
    output pfa_result_t       result,
    output pfa_ram_req_t      ram_req,
    input  logic [FLAG_W-1:0] ram_rdata
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_BOUND = 7'b0001000,
        ST_WALK  = 7'b0010000,
        ST_MARK  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } pfa_state_t;

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_DISABLE,
        MODE_FREE,
        MODE_SEARCH
    } pfa_mode_t;

    pfa_state_t             state_reg, state_next;
    pfa_cmd_t               cmd_reg, cmd_next;
    logic [31:0]            aligned_reg, aligned_next;
    pfa_mode_t              mode_reg, mode_next;
    logic [SPAN_W-1:0]      span_reg, span_next;
    logic [PAGE_NUM_W-1:0]  start_reg, start_next;
    logic [FRAME_CNT_W-1:0] cur_reg, cur_next;
    logic [FRAME_CNT_W-1:0] limit_reg, limit_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [FRAME_IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [FRAME_CNT_W-1:0] run_reg, run_next;
    logic [FRAME_IDX_W-1:0] off_reg, off_next;
    logic [FRAME_CNT_W-1:0] pool_reg, pool_next;
    logic [31:0]            used_reg, used_next;
    logic                   fgv_reg, fgv_next;
    logic [FRAME_IDX_W-1:0] fgi_reg, fgi_next;
    logic [1:0]             status_reg, status_next;
    logic [31:0]            base_reg, base_next;
    logic                   done_reg, done_next;
    pfa_result_t            result_reg, result_next;

    logic [31:0]            pend_base;
    logic [31:0]            off_base;
    logic                   excluded;
    logic [PAGE_NUM_W-1:0]  dis_pages;
    logic [END_W-1:0]       end_pages;
    logic [FRAME_CNT_W-1:0] run_inc;
    logic [FRAME_IDX_W-1:0] off_start;
    logic                   found;

    assign pend_base = 32'({pend_idx_reg, {PAGE_SHIFT{1'b0}}});
    assign off_base  = 32'({off_reg, {PAGE_SHIFT{1'b0}}});

    assign excluded = (pend_base >= LOW_WIN_LO  && pend_base <= LOW_WIN_HI)
                   || (pend_base >= HOLE_WIN_LO && pend_base <= HOLE_WIN_HI)
                   || (pend_base >= HIGH_WIN_LO && pend_base <= HIGH_WIN_HI)
                   || (pend_base <= image_top);

    // disabling always covers at least one frame
    assign dis_pages = (cmd_reg.length_bytes[31:PAGE_SHIFT] == '0) ?
                       PAGE_NUM_W'(1) : cmd_reg.length_bytes[31:PAGE_SHIFT];

    // region adds stop at the first frame whose base reaches the byte end
    assign end_pages = (mode_reg == MODE_ADD) ?
                       (END_W'(span_reg[SPAN_W-1:PAGE_SHIFT])
                        + END_W'(|span_reg[PAGE_SHIFT-1:0])) :
                       span_reg[END_W-1:0];

    assign run_inc   = run_reg + FRAME_CNT_W'(1);
    assign off_start = (run_reg == '0) ? pend_idx_reg : off_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        aligned_next    = aligned_reg;
        mode_next       = mode_reg;
        span_next       = span_reg;
        start_next      = start_reg;
        cur_next        = cur_reg;
        limit_next      = limit_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        run_next        = run_reg;
        off_next        = off_reg;
        pool_next       = pool_reg;
        used_next       = used_reg;
        fgv_next        = fgv_reg;
        fgi_next        = fgi_reg;
        status_next     = status_reg;
        base_next       = base_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        found           = 1'b0;

        ram_req.we    = 1'b0;
        ram_req.waddr = pend_idx_reg;
        ram_req.wdata = FLAG_NONE;
        ram_req.raddr = cur_reg[FRAME_IDX_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cur_reg[FRAME_IDX_W-1:0];
                cur_next      = cur_reg + FRAME_CNT_W'(1);
                if (cur_reg[FRAME_IDX_W-1:0] == LAST_FRAME)
                begin
                    cur_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd;
                    aligned_next = (cmd.address + PAGE_MASK) & ~PAGE_MASK;
                    state_next   = ST_PREP;
                end
            end

            ST_PREP:
            begin
                base_next   = '0;
                status_next = STATUS_OK;
                case (cmd_reg.op)
                    OP_REGION:
                    begin
                        start_next = aligned_reg[31:PAGE_SHIFT];
                        if (cmd_reg.region_usable && aligned_reg >= MIN_REGION_BASE)
                        begin
                            mode_next = MODE_ADD;
                            span_next = SPAN_W'(aligned_reg)
                                      + SPAN_W'(cmd_reg.length_bytes);
                        end
                        else
                        begin
                            mode_next = MODE_DISABLE;
                            span_next = SPAN_W'(aligned_reg[31:PAGE_SHIFT])
                                      + SPAN_W'(dis_pages);
                        end
                        state_next = ST_BOUND;
                    end

                    OP_ALLOC:
                    begin
                        start_next = '0;
                        if (cmd_reg.frame_count == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (SPAN_W'(used_reg) + SPAN_W'(cmd_reg.frame_count)
                                 >= SPAN_W'(pool_reg))
                        begin
                            status_next = STATUS_NO_MEMORY;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            mode_next  = MODE_SEARCH;
                            span_next  = SPAN_W'(fgi_reg) + SPAN_W'(pool_reg);
                            state_next = ST_BOUND;
                        end
                    end

                    OP_FREE:
                    begin
                        if (cmd_reg.address == '0)
                        begin
                            status_next = STATUS_NULL_FREE;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            mode_next  = MODE_FREE;
                            start_next = cmd_reg.address[31:PAGE_SHIFT];
                            span_next  = SPAN_W'(cmd_reg.address[31:PAGE_SHIFT])
                                       + SPAN_W'(cmd_reg.frame_count);
                            state_next = ST_BOUND;
                        end
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_BOUND:
            begin
                if (end_pages > END_W'(NUM_FRAMES))
                begin
                    limit_next = FRAME_CNT_W'(NUM_FRAMES);
                end
                else
                begin
                    limit_next = end_pages[FRAME_CNT_W-1:0];
                end
                // a start beyond the table walks nothing
                if (END_W'(start_reg) >= END_W'(NUM_FRAMES))
                begin
                    limit_next = '0;
                    cur_next   = '0;
                end
                else
                begin
                    cur_next = FRAME_CNT_W'(start_reg);
                end
                run_next   = '0;
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                if (pend_valid_reg)
                begin
                    case (mode_reg)
                        MODE_ADD:
                        begin
                            if (!excluded && !ram_rdata[FLAG_AVAIL_BIT])
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.wdata = FLAG_AVAIL;
                                pool_next     = pool_reg + FRAME_CNT_W'(1);
                                if (!fgv_reg)
                                begin
                                    fgv_next = 1'b1;
                                    fgi_next = pend_idx_reg;
                                end
                            end
                        end

                        MODE_DISABLE:
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.wdata = FLAG_NONE;
                            if (ram_rdata[FLAG_AVAIL_BIT])
                            begin
                                pool_next = pool_reg - FRAME_CNT_W'(1);
                            end
                        end

                        MODE_FREE:
                        begin
                            if (ram_rdata[FLAG_USED_BIT])
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.wdata = ram_rdata & ~FLAG_USED;
                                used_next     = used_reg - 32'd1;
                            end
                        end

                        MODE_SEARCH:
                        begin
                            if (!ram_rdata[FLAG_AVAIL_BIT] || ram_rdata[FLAG_USED_BIT])
                            begin
                                run_next = '0;
                            end
                            else
                            begin
                                off_next = off_start;
                                run_next = run_inc;
                                if (32'(run_inc) >= 32'(cmd_reg.frame_count))
                                begin
                                    found = 1'b1;
                                end
                            end
                        end

                        default:
                        begin
                        end
                    endcase
                end

                if (found)
                begin
                    // the read already in flight is dropped
                    cur_next   = FRAME_CNT_W'(off_start);
                    state_next = ST_MARK;
                end
                else if (cur_reg < limit_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = cur_reg[FRAME_IDX_W-1:0];
                    cur_next        = cur_reg + FRAME_CNT_W'(1);
                end
                else if (!pend_valid_reg)
                begin
                    if (mode_reg == MODE_SEARCH)
                    begin
                        status_next = STATUS_NO_RUN;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_MARK:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cur_reg[FRAME_IDX_W-1:0];
                ram_req.wdata = FLAG_ALLOC;
                cur_next      = cur_reg + FRAME_CNT_W'(1);
                run_next      = run_reg - FRAME_CNT_W'(1);
                if (run_reg == FRAME_CNT_W'(1))
                begin
                    used_next  = used_reg + 32'(cmd_reg.frame_count);
                    base_next  = off_base;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                done_next                = 1'b1;
                result_next.base_address = base_reg;
                result_next.status       = status_reg;
                result_next.total_frames = COUNT_W'(32'(pool_reg));
                result_next.used_frames  = used_reg[COUNT_W-1:0];
                state_next               = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cur_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pool_reg       <= '0;
            used_reg       <= '0;
            fgv_reg        <= 1'b0;
            fgi_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            pend_valid_reg <= pend_valid_next;
            pool_reg       <= pool_next;
            used_reg       <= used_next;
            fgv_reg        <= fgv_next;
            fgi_reg        <= fgi_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        aligned_reg  <= aligned_next;
        mode_reg     <= mode_next;
        span_reg     <= span_next;
        start_reg    <= start_next;
        limit_reg    <= limit_next;
        pend_idx_reg <= pend_idx_next;
        run_reg      <= run_next;
        off_reg      <= off_next;
        status_reg   <= status_next;
        base_reg     <= base_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hdl/page_frame_allocator_unit.sv */
// ============================================================================
// page_frame_allocator_unit: first-fit contiguous page frame allocator
// Keeps a 4 KB frame table with available and used flags; adds or disables
// regions, allocates and frees runs of frames.
// ============================================================================
// Usage
//   Command beat: cmd is taken at a rising edge where start is high and busy
//   is low. One result beat follows each command: result is valid for exactly
//   one cycle while done is high, and the receiver has to take it then.
//   image_top_wdata (last byte of the kernel image) is written when
//   image_top_we is high; write it only while no command is in flight.
// Sequencing
//   Commands that touch frames walk the flag table one frame per cycle through
//   the single read port of the flag memory, whose read data is registered.
//   Commands that touch no frame (zero-length alloc, out of memory, null free,
//   op 3) go from the prepare state straight to done. A successful allocation
//   stops its search at the frame that completes the run, then marks the frames
//   of the run one per cycle before done is strobed.
// Reset
//   After rst_n is released the whole flag table is cleared, one entry per
//   cycle; busy stays high meanwhile. The image top register can be written
//   during that pass.
// ============================================================================
module page_frame_allocator_unit
    import pfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  pfa_cmd_t    cmd,
    output logic        busy,
    output logic        done,
    output pfa_result_t result,
    input  logic        image_top_we,
    input  logic [31:0] image_top_wdata
);

    logic [31:0]       image_top_reg;
    pfa_ram_req_t      ram_req;
    logic [FLAG_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_top_reg <= '0;
        end
        else if (image_top_we)
        begin
            image_top_reg <= image_top_wdata;
        end
    end

    pfa_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .image_top  (image_top_reg),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    pfa_flag_ram u_flag_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule
